// ----- design/hidkd_pkg.sv -----
// hidkd_pkg: shared constants, types and the usage-code mapping function
`timescale 1ns / 1ps

package hidkd_pkg;

	localparam int unsigned KeySlotsDefault = 6;
	localparam int unsigned ReportSlots     = 6;

	// key classes on the result word
	localparam logic [3:0] ClsNone  = 4'd0;
	localparam logic [3:0] ClsChar  = 4'd1;
	localparam logic [3:0] ClsUp    = 4'd2;
	localparam logic [3:0] ClsDown  = 4'd3;
	localparam logic [3:0] ClsLeft  = 4'd4;
	localparam logic [3:0] ClsRight = 4'd5;
	localparam logic [3:0] ClsEnter = 4'd6;
	localparam logic [3:0] ClsEsc   = 4'd7;
	localparam logic [3:0] ClsTab   = 4'd8;
	localparam logic [3:0] ClsHome  = 4'd9;
	localparam logic [3:0] ClsEnd   = 4'd10;
	localparam logic [3:0] ClsPgUp  = 4'd11;
	localparam logic [3:0] ClsPgDn  = 4'd12;

	// hid usage codes
	localparam logic [7:0] UsgEmpty     = 8'h00;
	localparam logic [7:0] UsgUp        = 8'h52;
	localparam logic [7:0] UsgDown      = 8'h51;
	localparam logic [7:0] UsgLeft      = 8'h50;
	localparam logic [7:0] UsgRight     = 8'h4F;
	localparam logic [7:0] UsgEnter     = 8'h28;
	localparam logic [7:0] UsgEsc       = 8'h29;
	localparam logic [7:0] UsgTab       = 8'h2B;
	localparam logic [7:0] UsgHome      = 8'h4A;
	localparam logic [7:0] UsgEnd       = 8'h4D;
	localparam logic [7:0] UsgPgUp      = 8'h4B;
	localparam logic [7:0] UsgPgDn      = 8'h4E;
	localparam logic [7:0] UsgLetterA   = 8'h04;
	localparam logic [7:0] UsgLetterZ   = 8'h1D;
	localparam logic [7:0] UsgDigitOne  = 8'h1E;
	localparam logic [7:0] UsgDigitZero = 8'h27;
	localparam logic [7:0] UsgSpace     = 8'h2C;

	// modifier masks
	localparam logic [7:0] ModShift = 8'h22;
	localparam logic [7:0] ModAlt   = 8'h44;

	// ascii anchors
	localparam logic [6:0] AscUpperA = 7'h41;
	localparam logic [6:0] AscCase   = 7'h20;
	localparam logic [6:0] AscOne    = 7'h31;
	localparam logic [6:0] AscZero   = 7'h30;
	localparam logic [6:0] AscSpace  = 7'h20;
	localparam logic [6:0] AscNull   = 7'h00;

	typedef struct packed {
		logic       found;
		logic [3:0] key_class;
		logic [6:0] char_code;
		logic       alt_held;
	} key_map_t;

	function automatic key_map_t map_code(input logic [7:0] code, input logic [7:0] mods);
		key_map_t   m;
		logic [6:0] upper;
		m.found     = 1'b1;
		m.key_class = ClsChar;
		m.char_code = AscNull;
		m.alt_held  = 1'b0;
		upper       = AscUpperA + (code[6:0] - UsgLetterA[6:0]);
		unique case (code)
			UsgUp:    m.key_class = ClsUp;
			UsgDown:  m.key_class = ClsDown;
			UsgLeft:  m.key_class = ClsLeft;
			UsgRight: m.key_class = ClsRight;
			UsgEnter: m.key_class = ClsEnter;
			UsgEsc:   m.key_class = ClsEsc;
			UsgTab:   m.key_class = ClsTab;
			UsgHome:  m.key_class = ClsHome;
			UsgEnd:   m.key_class = ClsEnd;
			UsgPgUp:  m.key_class = ClsPgUp;
			UsgPgDn:  m.key_class = ClsPgDn;
			UsgSpace: m.char_code = AscSpace;
			UsgDigitZero: m.char_code = AscZero;
			default: begin
				if (code >= UsgLetterA && code <= UsgLetterZ) begin
					if ((mods & ModAlt) != 8'h00) begin
						m.char_code = upper;
						m.alt_held  = 1'b1;
					end else if ((mods & ModShift) != 8'h00) begin
						m.char_code = upper;
					end else begin
						m.char_code = upper + AscCase;
					end
				end else if (code >= UsgDigitOne && code < UsgDigitZero) begin
					m.char_code = AscOne + (code[6:0] - UsgDigitOne[6:0]);
				end else begin
					m.found     = 1'b0;
					m.key_class = ClsNone;
				end
			end
		endcase
		return m;
	endfunction

endpackage

// ----- design/hid_report_new_key_decoder_top.sv -----
// hid_report_new_key_decoder_top: boot keyboard report to first new mapped key
`timescale 1ns / 1ps

// channel  direction  handshake            payload
// in       to block   in_valid / in_stall  modifier_bits, slot_zero .. slot_five
// out      from block out_valid / out_stall key_class, char_code, alt_held
//
// one result word for every report word, one word per cycle sustained while out_stall stays low
// each report passes the input register, then the result register
// the key-slot compare and mapping sit between those two registers
// arst_n clears the held-key store (no keys held) and both valid flags
// in_stall rises only while the input register is full and the result
// register is full and stalled

module hid_report_new_key_decoder_top #(
	parameter int unsigned KEY_SLOTS = hidkd_pkg::KeySlotsDefault
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] modifier_bits,
	input  logic [7:0] slot_zero,
	input  logic [7:0] slot_one,
	input  logic [7:0] slot_two,
	input  logic [7:0] slot_three,
	input  logic [7:0] slot_four,
	input  logic [7:0] slot_five,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [3:0] key_class,
	output logic [6:0] char_code,
	output logic       alt_held
);

	// report slots gathered into an array for the scan
	logic [7:0] slot_in [hidkd_pkg::ReportSlots];

	// input register
	logic       valid_s1;
	logic [7:0] mods_s1;
	logic [7:0] slot_s1 [KEY_SLOTS];

	// keycodes of the last report that left the input register
	logic [7:0] prev_q [KEY_SLOTS];

	// result register
	logic       valid_s2;
	logic [3:0] class_s2;
	logic [6:0] char_s2;
	logic       alt_s2;

	logic               adv_s2;
	logic               adv_s1;
	logic [KEY_SLOTS-1:0] held;
	hidkd_pkg::key_map_t  map [KEY_SLOTS];
	hidkd_pkg::key_map_t  pick;

	assign slot_in[0] = slot_zero;
	assign slot_in[1] = slot_one;
	assign slot_in[2] = slot_two;
	assign slot_in[3] = slot_three;
	assign slot_in[4] = slot_four;
	assign slot_in[5] = slot_five;

	// result register frees when empty or taken; input register moves with it
	assign adv_s2   = !valid_s2 || !out_stall;
	assign adv_s1   = valid_s1 && adv_s2;
	assign in_stall = valid_s1 && !adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			mods_s1 <= modifier_bits;
			for (int i = 0; i < KEY_SLOTS; i++) begin
				slot_s1[i] <= slot_in[i];
			end
		end
	end

	// a slot is held when its code sits anywhere in the last report
	always_comb begin
		for (int i = 0; i < KEY_SLOTS; i++) begin
			held[i] = 1'b0;
			for (int j = 0; j < KEY_SLOTS; j++) begin
				if (prev_q[j] == slot_s1[i]) begin
					held[i] = 1'b1;
				end
			end
			map[i] = hidkd_pkg::map_code(slot_s1[i], mods_s1);
		end
	end

	// first slot with a new, nonzero, mapped key wins
	always_comb begin
		pick.found     = 1'b0;
		pick.key_class = hidkd_pkg::ClsNone;
		pick.char_code = hidkd_pkg::AscNull;
		pick.alt_held  = 1'b0;
		for (int i = KEY_SLOTS - 1; i >= 0; i--) begin
			if (slot_s1[i] != hidkd_pkg::UsgEmpty && !held[i] && map[i].found) begin
				pick = map[i];
			end
		end
	end

	// held-key store follows each report as it is decoded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < KEY_SLOTS; i++) begin
				prev_q[i] <= hidkd_pkg::UsgEmpty;
			end
		end else if (adv_s1) begin
			for (int i = 0; i < KEY_SLOTS; i++) begin
				prev_q[i] <= slot_s1[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			class_s2 <= pick.key_class;
			char_s2  <= pick.char_code;
			alt_s2   <= pick.alt_held;
		end
	end

	assign out_valid = valid_s2;
	assign key_class = class_s2;
	assign char_code = char_s2;
	assign alt_held  = alt_s2;

`ifndef ASSERT_OFF
	// only a character result carries a character or the alt flag
	a_char_only: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && class_s2 != hidkd_pkg::ClsChar |-> char_s2 == 7'd0 && !alt_s2)
		else $error("non-char result with char payload");

	// the alt flag comes only with an upper case letter
	a_alt_upper: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && alt_s2 |-> char_s2 >= 7'h41 && char_s2 <= 7'h5A)
		else $error("alt flag without upper case letter");

	// a stall on the input means a full input register behind a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && valid_s2 && out_stall)
		else $error("input stalled without back pressure");

	// the held-key store takes the report that just left the input register
	a_prev_update: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> prev_q[0] == $past(slot_s1[0]))
		else $error("held-key store not updated");

	// the store stays put while no report is decoded
	a_prev_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv_s1 |=> $stable(prev_q[0]))
		else $error("held-key store changed without a report");
`endif

endmodule
